FILE: hw/rtl/hfu_pkg.sv
package hfu_pkg;

  // fixed field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 11;
  localparam int unsigned SdlW    = 12;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned FppW    = 11;

  // rfc 6184 codes and masks
  localparam logic [4:0]       FuAType    = 5'd28;
  localparam logic [ByteW-1:0] FuATypeB   = 8'd28;
  localparam logic [SdlW-1:0]  TsHdrBytes = 12'd4;
  localparam logic [FppW-1:0]  FppReset   = 11'd1;

  // one outgoing media chunk
  typedef struct packed {
    logic [ByteW-1:0] first_byte;
    logic [ByteW-1:0] second_byte;
    logic [LenW-1:0]  chunk_len;
    logic             is_partial;
    logic             end_of_nalu;
    logic             has_nalu_time;
    logic [TimeW-1:0] nalu_time;
    logic [TimeW-1:0] avtp_time;
  } hfu_in_t;

  // packet descriptor for the chunk
  typedef struct packed {
    logic              rewrite_header;
    logic [ByteW-1:0]  fu_indicator;
    logic [ByteW-1:0]  fu_header;
    logic              avtp_time_valid;
    logic [TimeW-1:0]  avtp_time_out;
    logic              h264_time_valid;
    logic [TimeW-1:0]  h264_time;
    logic [SdlW-1:0]   stream_len;
    logic [ByteW-1:0]  sequence_number;
    logic [CountW-1:0] media_total;
    logic [CountW-1:0] time_error_count;
  } hfu_out_t;

  // state carried from chunk to chunk
  typedef struct packed {
    logic              nalu_in_progress;
    logic [ByteW-1:0]  saved_nalu_header;
    logic              nalu_time_ok;
    logic [TimeW-1:0]  saved_nalu_time;
    logic [ByteW-1:0]  seq_counter;
    logic [CountW-1:0] media_counter;
    logic [CountW-1:0] time_error_counter;
  } hfu_state_t;

endpackage

FILE: hw/rtl/hfu_pipe_reg.sv
module hfu_pipe_reg #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q;
  logic [Width-1:0] data_q;

  // stage takes a new request when empty or being drained
  assign ready_o = !valid_q || ready_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/hfu_core.sv
module hfu_core import hfu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  hfu_in_t         item_i,
  input  logic [FppW-1:0] fpp_i,
  output hfu_out_t        result_o
);

  hfu_state_t state_q, state_d;

  logic            fresh;
  logic            fu_first;
  logic            single;
  logic [ByteW-1:0] hdr;
  logic            err_bump;
  logic [CountW-1:0] add_val;

  // chunk classification
  assign fresh    = !state_q.nalu_in_progress;
  assign fu_first = fresh && (item_i.first_byte == FuATypeB);
  assign single   = fresh && !fu_first;

  // timestamp misuse: missing at a start, or present mid-nalu
  assign err_bump = item_i.has_nalu_time != fresh;

  assign add_val = item_i.is_partial ? CountW'(item_i.chunk_len)
                                     : CountW'(fpp_i);

  // next state
  always_comb begin
    state_d = state_q;
    if (single) begin
      state_d.saved_nalu_header = item_i.first_byte;
    end else if (fu_first) begin
      state_d.saved_nalu_header = item_i.second_byte;
    end
    if (fresh) begin
      state_d.nalu_time_ok = item_i.has_nalu_time;
      if (item_i.has_nalu_time) begin
        state_d.saved_nalu_time = item_i.nalu_time;
      end
    end
    if (err_bump && (state_q.time_error_counter != '1)) begin
      state_d.time_error_counter = state_q.time_error_counter + CountW'(1);
    end
    state_d.nalu_in_progress = !item_i.end_of_nalu;
    state_d.seq_counter      = state_q.seq_counter + ByteW'(1);
    state_d.media_counter    = state_q.media_counter + add_val;
  end

  assign hdr = state_d.saved_nalu_header;

  // result fields
  always_comb begin
    result_o.rewrite_header     = !single;
    result_o.fu_indicator       = single ? '0 : {1'b0, hdr[6:5], FuAType};
    result_o.fu_header          = single ? '0
        : {fu_first, !fu_first && item_i.end_of_nalu, 1'b0, hdr[4:0]};
    result_o.avtp_time_valid    = item_i.end_of_nalu;
    result_o.avtp_time_out      = item_i.end_of_nalu ? item_i.avtp_time : '0;
    result_o.h264_time_valid    = state_d.nalu_time_ok;
    result_o.h264_time          = state_d.nalu_time_ok ? state_d.saved_nalu_time : '0;
    result_o.stream_len         = SdlW'(item_i.chunk_len) + TsHdrBytes;
    result_o.sequence_number    = state_d.seq_counter;
    result_o.media_total        = state_d.media_counter;
    result_o.time_error_count   = state_d.time_error_counter;
  end

  // state registers, updated once per chunk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance_i) begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/h264_fu_a_packetizer.sv
// H.264 FU-A packetizer, talker side of an AVTP compressed video stream.
// Input channel (in_valid_i / in_ready_o / in_data_i): one request per
// outgoing media chunk with its two leading bytes, length, flags and times.
// Output channel (out_valid_o / out_ready_i / out_data_o): one packet
// descriptor per chunk, in order: FU indicator and header, timestamps,
// stream data length, sequence number, media count and timestamp error count.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes
// the media units added per full chunk; always ready, to be written only
// while the block idles.
// A chunk passes from the input register through the chunk logic into the output register,
// from which its descriptor is offered on the output channel.
// Throughput: one chunk per cycle while out_ready_i stays high; the input register and the output
// register each hold one request, the chunk logic between them holds none.
// Reset clears all counters and NALU state, empties both registers and sets
// the per-chunk media increment to 1.
// When the receiver stalls, the output register holds its descriptor and the
// input register keeps one more chunk; after that in_ready_o falls.
module h264_fu_a_packetizer import hfu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hfu_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hfu_out_t        out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [FppW-1:0] cfg_data_i
);

  logic            stg_valid;
  logic            stg_ready;
  hfu_in_t         stg_data;
  hfu_out_t        result;
  logic [FppW-1:0] fpp_q;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpp_q <= FppReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fpp_q <= cfg_data_i;
    end
  end

  // input register
  hfu_pipe_reg #(
    .Width($bits(hfu_in_t))
  ) u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .ready_o(in_ready_o),
    .data_i (in_data_i),
    .valid_o(stg_valid),
    .ready_i(stg_ready),
    .data_o (stg_data)
  );

  // chunk logic and carried state
  hfu_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(stg_valid && stg_ready),
    .item_i   (stg_data),
    .fpp_i    (fpp_q),
    .result_o (result)
  );

  // result register
  hfu_pipe_reg #(
    .Width($bits(hfu_out_t))
  ) u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(stg_valid),
    .ready_o(stg_ready),
    .data_i (result),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_data_o)
  );

endmodule

FILE: hw/rtl/hfu_checker.sv
module hfu_checker import hfu_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input hfu_out_t out_data_o
);

  logic out_acc;
  assign out_acc = out_valid_o && out_ready_i;

  // stalled descriptor stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("descriptor dropped while stalled");

  // stalled descriptor does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("descriptor changed while stalled");

  // descriptors accepted back to back carry consecutive sequence numbers
  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc ##1 out_acc |->
      out_data_o.sequence_number == $past(out_data_o.sequence_number) + 8'd1)
    else $error("sequence number skipped");

  // error count never goes down between descriptors accepted back to back
  a_err_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc ##1 out_acc |->
      out_data_o.time_error_count >= $past(out_data_o.time_error_count))
    else $error("time error count decreased");

  // single nalu packets carry no fu bytes
  a_single_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.rewrite_header |->
      out_data_o.fu_indicator == '0 && out_data_o.fu_header == '0)
    else $error("fu bytes set on single nalu packet");

endmodule

bind h264_fu_a_packetizer hfu_checker u_hfu_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
